/* src/tlc_pkg.sv */
// Shared types and codes for the two-level cache hit/miss tracker.
`timescale 1ns / 1ps
`default_nettype none

package tlc_pkg;

   // Access kinds
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // Configuration port geometry and register indexes
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 5;
   localparam logic [CSR_INDEX_W-1:0] CSR_L1_OFFSET = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_L1_INDEX  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_L1_WAYS   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_L2_OFFSET = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_L2_INDEX  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_L2_WAYS   = 3'd5;

   // Per-level lookup outcome
   typedef enum logic [2:0] {
      STAT_NONE    = 3'd0,
      STAT_RD_HIT  = 3'd1,
      STAT_RD_MISS = 3'd2,
      STAT_WR_HIT  = 3'd3,
      STAT_WR_MISS = 3'd4
   } status_type;

   typedef struct packed {
      logic        op;
      logic [31:0] address;
   } req_type;

   typedef struct packed {
      status_type l1_status;
      status_type l2_status;
   } rsp_type;

   // Sequencer states
   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_L1,
      S_L2,
      S_FILL
   } state_type;

   // Status of the shared way-compare unit
   typedef struct packed {
      logic hit;
      logic done;
   } probe_stat_type;

endpackage

`default_nettype wire

/* src/two_level_cache_hit_miss_tracker.sv */
// Top level of the two-level cache hit/miss tracker: configuration, sequencer, result register.
`timescale 1ns / 1ps
`default_nettype none

// Tracks hits and misses of a two-level set-associative cache (tags and valid
// bits only, no data). Raise start with a read or write transaction on req_payload
// while busy is low; the transaction is taken at that clock edge and busy rises.
// Exactly one result comes back on rsp_payload, marked by a one-cycle rsp_valid
// pulse; the receiver cannot stall it, so capture it in that cycle. One shared
// compare unit walks the ways of a set, one tag per cycle from each level's tag
// memory, first for L1 and, on an L1 miss, for L2; a read miss then passes through
// a fill state that writes the fills. After reset the block sweeps its
// valid/round-robin row memories to zero, one row per cycle, and holds busy
// high until both sweeps end; configuration writes are taken during the sweep.
// Write configuration only while idle.
module two_level_cache_hit_miss_tracker #(
   parameter int L1_MAX_SETS = 256,
   parameter int L1_MAX_WAYS = 8,
   parameter int L2_MAX_SETS = 1024,
   parameter int L2_MAX_WAYS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire tlc_pkg::req_type                    req_payload,
   output logic                                     rsp_valid,
   output tlc_pkg::rsp_type                         rsp_payload,
   input  wire logic                                csr_we,
   input  wire logic [tlc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [tlc_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import tlc_pkg::*;

   // Index widths are limited to floor(log2(max sets))
   localparam int L1_LIM = $clog2(L1_MAX_SETS + 1) - 1;
   localparam int L2_LIM = $clog2(L2_MAX_SETS + 1) - 1;
   localparam int L1_SW  = (L1_LIM > 0) ? L1_LIM : 1;
   localparam int L2_SW  = (L2_LIM > 0) ? L2_LIM : 1;
   localparam int L1_WW  = (L1_MAX_WAYS > 1) ? $clog2(L1_MAX_WAYS) : 1;
   localparam int L2_WW  = (L2_MAX_WAYS > 1) ? $clog2(L2_MAX_WAYS) : 1;
   localparam int L1_WC  = $clog2(L1_MAX_WAYS + 1);
   localparam int L2_WC  = $clog2(L2_MAX_WAYS + 1);
   localparam int MW     = (L1_MAX_WAYS > L2_MAX_WAYS) ? L1_MAX_WAYS : L2_MAX_WAYS;
   localparam int MWW    = (MW > 1) ? $clog2(MW) : 1;
   localparam int MWC    = $clog2(MW + 1);

   // Configuration registers
   logic [3:0] l1_off_ff, l1_idx_ff, l1_ways_ff;
   logic [3:0] l2_off_ff, l2_idx_ff;
   logic [4:0] l2_ways_ff;

   // Transaction context
   state_type        state_ff, state_in;
   req_type          req_ff, req_in;
   logic [31:0]      tag1_ff, tag1_in, tag2_ff, tag2_in;
   logic [L1_SW-1:0] set1_ff, set1_in;
   logic [L2_SW-1:0] set2_ff, set2_in;
   logic [L1_WC-1:0] ways1_ff, ways1_in;
   logic [L2_WC-1:0] ways2_ff, ways2_in;
   logic             l2_hit_ff, l2_hit_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   // Address split at accept time
   logic [3:0]  idx1, idx2;
   logic [5:0]  sh1, sh2;
   logic [31:0] set1_full, set2_full;

   // Sequencer outputs
   logic accept;
   logic probe_active;
   logic probe_l2;
   logic fill1, fill2;
   logic finish;

   // Level stores and shared compare unit
   logic [31:0]            l1_tag_rd, l2_tag_rd;
   logic [L1_MAX_WAYS-1:0] l1_valid;
   logic [L2_MAX_WAYS-1:0] l2_valid;
   logic                   l1_ready, l2_ready;
   logic [MWW-1:0]         probe_way;
   probe_stat_type         probe_stat;
   logic [MWC-1:0]         probe_ways;
   logic [MW-1:0]          probe_valid;
   logic [31:0]            probe_tag_rd, probe_tag_ref;

   function automatic status_type status_of(input logic hit, input logic wr);
      status_type s;
      if (wr == OP_WRITE) begin
         s = hit ? STAT_WR_HIT : STAT_WR_MISS;
      end else begin
         s = hit ? STAT_RD_HIT : STAT_RD_MISS;
      end
      return s;
   endfunction

   // ---------------------------------------------------------------
   // Configuration port
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         l1_off_ff  <= 4'd5;
         l1_idx_ff  <= 4'd6;
         l1_ways_ff <= 4'd4;
         l2_off_ff  <= 4'd6;
         l2_idx_ff  <= 4'd8;
         l2_ways_ff <= 5'd8;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_L1_OFFSET: l1_off_ff  <= csr_wdata[3:0];
            CSR_L1_INDEX:  l1_idx_ff  <= csr_wdata[3:0];
            CSR_L1_WAYS:   l1_ways_ff <= csr_wdata[3:0];
            CSR_L2_OFFSET: l2_off_ff  <= csr_wdata[3:0];
            CSR_L2_INDEX:  l2_idx_ff  <= csr_wdata[3:0];
            CSR_L2_WAYS:   l2_ways_ff <= csr_wdata;
            default: begin
               // drop writes to unused indexes
            end
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Address split and way clamp, taken once per transaction
   // ---------------------------------------------------------------
   always_comb begin
      idx1 = (32'(l1_idx_ff) > L1_LIM) ? 4'(L1_LIM) : l1_idx_ff;
      idx2 = (32'(l2_idx_ff) > L2_LIM) ? 4'(L2_LIM) : l2_idx_ff;
      sh1  = 6'(l1_off_ff) + 6'(idx1);
      sh2  = 6'(l2_off_ff) + 6'(idx2);
      // a shift of 32 or more leaves an empty tag
      tag1_in   = req_payload.address >> sh1;
      tag2_in   = req_payload.address >> sh2;
      set1_full = (req_payload.address >> l1_off_ff) & ((32'd1 << idx1) - 32'd1);
      set2_full = (req_payload.address >> l2_off_ff) & ((32'd1 << idx2) - 32'd1);
      set1_in   = set1_full[L1_SW-1:0];
      set2_in   = set2_full[L2_SW-1:0];
      req_in    = req_payload;

      // zero ways acts as one, too many acts as the maximum
      if (l1_ways_ff == '0) begin
         ways1_in = L1_WC'(1);
      end else if (32'(l1_ways_ff) > L1_MAX_WAYS) begin
         ways1_in = L1_WC'(L1_MAX_WAYS);
      end else begin
         ways1_in = L1_WC'(l1_ways_ff);
      end
      if (l2_ways_ff == '0) begin
         ways2_in = L2_WC'(1);
      end else if (32'(l2_ways_ff) > L2_MAX_WAYS) begin
         ways2_in = L2_WC'(L2_MAX_WAYS);
      end else begin
         ways2_in = L2_WC'(l2_ways_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff   <= req_in;
         tag1_ff  <= tag1_in;
         tag2_ff  <= tag2_in;
         set1_ff  <= set1_in;
         set2_ff  <= set2_in;
         ways1_ff <= ways1_in;
         ways2_ff <= ways2_in;
      end
   end

   // ---------------------------------------------------------------
   // Sequencer: next state
   // ---------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (l1_ready && l2_ready) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               state_in = S_L1;
            end
         end
         S_L1: begin
            if (probe_stat.done) begin
               state_in = probe_stat.hit ? S_IDLE : S_L2;
            end
         end
         S_L2: begin
            if (probe_stat.done) begin
               state_in = (req_ff.op == OP_READ) ? S_FILL : S_IDLE;
            end
         end
         S_FILL: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------
   // Sequencer: outputs
   // ---------------------------------------------------------------
   always_comb begin
      busy         = 1'b1;
      accept       = 1'b0;
      probe_active = 1'b0;
      probe_l2     = 1'b0;
      fill1        = 1'b0;
      fill2        = 1'b0;
      finish       = 1'b0;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         S_CLEAR: begin
         end
         S_IDLE: begin
            busy   = 1'b0;
            accept = start;
         end
         S_L1: begin
            probe_active   = 1'b1;
            // an L1 hit ends the transaction, L2 stays unprobed
            finish         = probe_stat.done && probe_stat.hit;
            rsp_in.l1_status = status_of(1'b1, req_ff.op);
            rsp_in.l2_status = STAT_NONE;
         end
         S_L2: begin
            probe_active   = 1'b1;
            probe_l2       = 1'b1;
            // a write never allocates, so it ends here
            finish         = probe_stat.done && (req_ff.op == OP_WRITE);
            rsp_in.l1_status = status_of(1'b0, req_ff.op);
            rsp_in.l2_status = status_of(probe_stat.hit, req_ff.op);
         end
         S_FILL: begin
            fill1          = 1'b1;
            fill2          = !l2_hit_ff;
            finish         = 1'b1;
            rsp_in.l1_status = STAT_RD_MISS;
            rsp_in.l2_status = l2_hit_ff ? STAT_RD_HIT : STAT_RD_MISS;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      l2_hit_in    = (probe_l2 && probe_stat.done) ? probe_stat.hit : l2_hit_ff;
      rsp_valid_in = finish;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
         l2_hit_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         l2_hit_ff    <= l2_hit_in;
      end
   end

   // hold the last result in the payload register
   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // ---------------------------------------------------------------
   // Level stores and the shared compare unit
   // ---------------------------------------------------------------
   tlc_store #(
      .SET_W    (L1_SW),
      .MAX_WAYS (L1_MAX_WAYS)
   ) u_l1_store (
      .clock     (clock),
      .reset     (reset),
      .set_idx   (set1_ff),
      .rd_way    (probe_way[L1_WW-1:0]),
      .ways      (ways1_ff),
      .tag_in    (tag1_ff),
      .fill_en   (fill1),
      .tag_rd    (l1_tag_rd),
      .valid_row (l1_valid),
      .ready     (l1_ready)
   );

   tlc_store #(
      .SET_W    (L2_SW),
      .MAX_WAYS (L2_MAX_WAYS)
   ) u_l2_store (
      .clock     (clock),
      .reset     (reset),
      .set_idx   (set2_ff),
      .rd_way    (probe_way[L2_WW-1:0]),
      .ways      (ways2_ff),
      .tag_in    (tag2_ff),
      .fill_en   (fill2),
      .tag_rd    (l2_tag_rd),
      .valid_row (l2_valid),
      .ready     (l2_ready)
   );

   // steer the compare unit to the level being probed
   always_comb begin
      probe_ways    = probe_l2 ? MWC'(ways2_ff) : MWC'(ways1_ff);
      probe_valid   = probe_l2 ? MW'(l2_valid) : MW'(l1_valid);
      probe_tag_rd  = probe_l2 ? l2_tag_rd : l1_tag_rd;
      probe_tag_ref = probe_l2 ? tag2_ff : tag1_ff;
   end

   tlc_probe #(
      .MAX_WAYS (MW)
   ) u_probe (
      .clock     (clock),
      .reset     (reset),
      .active    (probe_active),
      .ways      (probe_ways),
      .valid_row (probe_valid),
      .tag_rd    (probe_tag_rd),
      .tag_ref   (probe_tag_ref),
      .rd_way    (probe_way),
      .stat      (probe_stat)
   );

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == S_L1 || state_ff == S_L2 || state_ff == S_FILL))
      else $error("result strobe without a transaction in flight");

   a_fill_after_l2: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FILL) |-> ($past(state_ff) == S_L2 && req_ff.op == OP_READ))
      else $error("fill cycle not preceded by an L2 probe of a read");

   a_l2_none_on_l1_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_ff.l2_status == STAT_NONE) ==
                        (rsp_ff.l1_status == STAT_RD_HIT || rsp_ff.l1_status == STAT_WR_HIT)))
      else $error("L2 status inconsistent with L1 outcome");

   a_no_fill_on_write: assert property (@(posedge clock) disable iff (reset)
      (fill1 || fill2) |-> (req_ff.op == OP_READ && l1_ready && l2_ready))
      else $error("fill for a write or during the row sweep");

endmodule

`default_nettype wire

/* src/tlc_store.sv */
// Tag memory, valid/round-robin row memory and fill victim selection for one cache level.
`timescale 1ns / 1ps
`default_nettype none

module tlc_store #(
   parameter int SET_W    = 8,
   parameter int MAX_WAYS = 8,
   localparam int WW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
   localparam int WC    = $clog2(MAX_WAYS + 1),
   localparam int ROWS  = 2 ** SET_W,
   localparam int ROW_W = MAX_WAYS + WW,
   localparam int TAGS  = 2 ** (SET_W + WW)
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [SET_W-1:0]    set_idx,
   input  wire logic [WW-1:0]       rd_way,
   input  wire logic [WC-1:0]       ways,
   input  wire logic [31:0]         tag_in,
   input  wire logic                fill_en,
   output logic      [31:0]         tag_rd,
   output logic      [MAX_WAYS-1:0] valid_row,
   output logic                     ready
);
   import tlc_pkg::*;

   logic [ROW_W-1:0] row_mem [ROWS];
   logic [31:0]      tag_mem [TAGS];

   logic [ROW_W-1:0]    row_rd_ff;
   logic [31:0]         tag_rd_ff;
   logic                clearing_ff, clearing_in;
   logic [SET_W-1:0]    clr_ff, clr_in;

   logic [MAX_WAYS-1:0] valid;
   logic [WW-1:0]       ptr;
   logic [WC-1:0]       ptr_w;
   logic                free_found;
   logic [WW-1:0]       free_way;
   logic [WW-1:0]       victim;
   logic [WW-1:0]       ptr_next;
   logic [ROW_W-1:0]    row_new;

   assign valid     = row_rd_ff[MAX_WAYS-1:0];
   assign ptr       = row_rd_ff[ROW_W-1:MAX_WAYS];
   assign ptr_w     = WC'(ptr);
   assign tag_rd    = tag_rd_ff;
   assign valid_row = valid;
   assign ready     = !clearing_ff;

   // Victim: lowest free way in use, else round-robin pointer
   always_comb begin
      free_found = 1'b0;
      free_way   = '0;
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (!free_found && (WC'(w) < ways) && !valid[w]) begin
            free_found = 1'b1;
            free_way   = WW'(w);
         end
      end
      if (free_found) begin
         victim   = free_way;
         ptr_next = ptr;
      end else begin
         victim   = (ptr_w < ways) ? ptr : '0;
         ptr_next = (ptr_w < ways - WC'(1)) ? ptr + WW'(1) : '0;
      end
      row_new = {ptr_next, valid | (MAX_WAYS'(1) << victim)};
   end

   // Row sweep after reset
   always_comb begin
      clr_in      = clr_ff + SET_W'(1);
      clearing_in = clearing_ff && (clr_ff != '1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_ff      <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_ff      <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         row_mem[clr_ff] <= '0;
      end else if (fill_en) begin
         row_mem[set_idx] <= row_new;
      end
      row_rd_ff <= row_mem[set_idx];
   end

   always_ff @(posedge clock) begin
      if (fill_en) begin
         tag_mem[{set_idx, victim}] <= tag_in;
      end
      tag_rd_ff <= tag_mem[{set_idx, rd_way}];
   end

endmodule

`default_nettype wire

/* src/tlc_probe.sv */
// Shared way-compare unit: walks the ways of one set, one tag compare per cycle.
`timescale 1ns / 1ps
`default_nettype none

module tlc_probe #(
   parameter int MAX_WAYS = 16,
   localparam int WW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
   localparam int WC = $clog2(MAX_WAYS + 1)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  active,
   input  wire logic [WC-1:0]         ways,
   input  wire logic [MAX_WAYS-1:0]   valid_row,
   input  wire logic [31:0]           tag_rd,
   input  wire logic [31:0]           tag_ref,
   output logic      [WW-1:0]         rd_way,
   output tlc_pkg::probe_stat_type    stat
);
   import tlc_pkg::*;

   logic [WC-1:0] cnt_ff, cnt_in;
   logic          pend_ff, pend_in;
   logic [WW-1:0] pend_way_ff, pend_way_in;
   logic          issue;
   logic          hit;
   logic          last;

   // Read for way cnt issues now, its tag is compared next cycle
   assign issue  = active && (cnt_ff < ways);
   assign rd_way = cnt_ff[WW-1:0];
   assign hit    = active && pend_ff && valid_row[pend_way_ff] && (tag_rd == tag_ref);
   assign last   = (WC'(pend_way_ff) == ways - WC'(1));

   always_comb begin
      stat.hit  = hit;
      stat.done = active && pend_ff && (hit || last);
   end

   always_comb begin
      if (!active || stat.done) begin
         cnt_in      = '0;
         pend_in     = 1'b0;
         pend_way_in = '0;
      end else begin
         cnt_in      = cnt_ff + WC'(issue);
         pend_in     = issue;
         pend_way_in = cnt_ff[WW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         pend_ff     <= 1'b0;
         pend_way_ff <= '0;
      end else begin
         cnt_ff      <= cnt_in;
         pend_ff     <= pend_in;
         pend_way_ff <= pend_way_in;
      end
   end

endmodule

`default_nettype wire

/* dv/two_level_cache_hit_miss_tracker_test.sv */
// Self-checking testbench for the two-level cache hit/miss tracker.
`timescale 1ns / 1ps

module two_level_cache_hit_miss_tracker_test;
   import tlc_pkg::*;

   localparam int L1_MAX_SETS = 256;
   localparam int L1_MAX_WAYS = 8;
   localparam int L2_MAX_SETS = 1024;
   localparam int L2_MAX_WAYS = 16;
   // Widest index each level can decode: floor(log2(max sets))
   localparam int L1_INDEX_LIMIT = $clog2(L1_MAX_SETS + 1) - 1;
   localparam int L2_INDEX_LIMIT = $clog2(L2_MAX_SETS + 1) - 1;
   localparam int LVL_L1 = 0;
   localparam int LVL_L2 = 1;

   // Settle margin after the outstanding results drain
   localparam int SETTLE_CYCLES  = 32;
   // The limit must clear the reset sweep, which holds busy high
   localparam int WATCHDOG_LIMIT = 4096;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_ITEMS    = 120;
   localparam int HOT_LINES      = 32;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   req_type                req_payload;
   logic                   rsp_valid;
   rsp_type                rsp_payload;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   two_level_cache_hit_miss_tracker #(
      .L1_MAX_SETS(L1_MAX_SETS),
      .L1_MAX_WAYS(L1_MAX_WAYS),
      .L2_MAX_SETS(L2_MAX_SETS),
      .L2_MAX_WAYS(L2_MAX_WAYS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_payload(rsp_payload),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Shadow copy of the geometry registers, updated as each CSR write lands
   logic [3:0] geo_l1_offset, geo_l1_index, geo_l1_ways;
   logic [3:0] geo_l2_offset, geo_l2_index;
   logic [4:0] geo_l2_ways;

   // Shadow tag directory for both levels, sized for the larger one.
   // Tags stay unknown until written; a tag is only ever compared behind its valid bit.
   logic [31:0] tag_dir   [0:1][0:L2_MAX_SETS-1][0:L2_MAX_WAYS-1];
   bit          valid_dir [0:1][0:L2_MAX_SETS-1][0:L2_MAX_WAYS-1];
   int          rr_pointer[0:1][0:L2_MAX_SETS-1];

   rsp_type     pending_status_q[$];
   logic [31:0] hot_lines[0:HOT_LINES-1];

   int gap_limit;
   int error_count;
   int accepted_count;
   int checked_count;
   int l1_hit_count;
   int l2_hit_count;
   int geometry_count;
   int idle_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Drive every input to a known value from time zero
   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_payload = '0;
      csr_we      = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= 50)
         $display("ERROR @%0t: %s", $time, msg);
   endtask

   function automatic int clamp_ways(input int ways, input int max_ways);
      if (ways == 0)
         return 1;
      return (ways > max_ways) ? max_ways : ways;
   endfunction

   // Split an address into set and tag; clamp the index to what the level can decode
   function automatic void split_address(input logic [31:0] addr, input int off,
                                         input int idx, input int idx_limit,
                                         output int set, output logic [31:0] tag);
      int eff_idx;
      eff_idx = (idx > idx_limit) ? idx_limit : idx;
      tag     = addr >> (off + eff_idx);
      set     = int'((addr >> off) & ((32'd1 << eff_idx) - 32'd1));
   endfunction

   function automatic bit holds_tag(input int lvl, input int set, input int ways,
                                    input logic [31:0] tag);
      for (int w = 0; w < ways; w++)
         if (valid_dir[lvl][set][w] && tag_dir[lvl][set][w] == tag)
            return 1'b1;
      return 1'b0;
   endfunction

   // Take the lowest invalid way, else the round-robin victim, then advance the pointer.
   // A pointer left beyond the ways in use (after shrinking) falls back to way 0.
   function automatic void fill_line(input int lvl, input int set, input int ways,
                                     input logic [31:0] tag);
      int victim;
      for (int w = 0; w < ways; w++) begin
         if (!valid_dir[lvl][set][w]) begin
            tag_dir[lvl][set][w]   = tag;
            valid_dir[lvl][set][w] = 1'b1;
            return;
         end
      end
      victim = (rr_pointer[lvl][set] < ways) ? rr_pointer[lvl][set] : 0;
      tag_dir[lvl][set][victim]   = tag;
      valid_dir[lvl][set][victim] = 1'b1;
      rr_pointer[lvl][set] = (rr_pointer[lvl][set] < ways - 1) ? rr_pointer[lvl][set] + 1 : 0;
   endfunction

   // Classify one access at both levels and update the shadow directory
   function automatic rsp_type predict_status(input req_type item);
      rsp_type     outcome;
      int          set1, set2, ways1, ways2;
      logic [31:0] tag1, tag2;
      split_address(item.address, geo_l1_offset, geo_l1_index, L1_INDEX_LIMIT, set1, tag1);
      split_address(item.address, geo_l2_offset, geo_l2_index, L2_INDEX_LIMIT, set2, tag2);
      ways1 = clamp_ways(geo_l1_ways, L1_MAX_WAYS);
      ways2 = clamp_ways(geo_l2_ways, L2_MAX_WAYS);
      outcome.l2_status = STAT_NONE;
      if (holds_tag(LVL_L1, set1, ways1, tag1)) begin
         // L1 hit: L2 never probed
         outcome.l1_status = (item.op == OP_WRITE) ? STAT_WR_HIT : STAT_RD_HIT;
      end else if (item.op == OP_WRITE) begin
         // Write miss: probe L2, allocate nowhere
         outcome.l1_status = STAT_WR_MISS;
         outcome.l2_status = holds_tag(LVL_L2, set2, ways2, tag2) ? STAT_WR_HIT : STAT_WR_MISS;
      end else begin
         outcome.l1_status = STAT_RD_MISS;
         if (holds_tag(LVL_L2, set2, ways2, tag2)) begin
            outcome.l2_status = STAT_RD_HIT;
         end else begin
            outcome.l2_status = STAT_RD_MISS;
            fill_line(LVL_L2, set2, ways2, tag2);
         end
         // The L1 victim is dropped, never written back to L2
         fill_line(LVL_L1, set1, ways1, tag1);
      end
      return outcome;
   endfunction

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------

   // Write one register; hold csr_we high so back-to-back writes stay glitch free
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      case (index)
         CSR_L1_OFFSET: geo_l1_offset = value[3:0];
         CSR_L1_INDEX:  geo_l1_index  = value[3:0];
         CSR_L1_WAYS:   geo_l1_ways   = value[3:0];
         CSR_L2_OFFSET: geo_l2_offset = value[3:0];
         CSR_L2_INDEX:  geo_l2_index  = value[3:0];
         CSR_L2_WAYS:   geo_l2_ways   = value;
         default: ;
      endcase
   endtask

   // Program all six geometry registers; call only with the block idle
   task automatic set_geometry(input logic [4:0] l1_off, input logic [4:0] l1_idx,
                               input logic [4:0] l1_ways, input logic [4:0] l2_off,
                               input logic [4:0] l2_idx, input logic [4:0] l2_ways);
      write_csr(CSR_L1_OFFSET, l1_off);
      write_csr(CSR_L1_INDEX,  l1_idx);
      write_csr(CSR_L1_WAYS,   l1_ways);
      write_csr(CSR_L2_OFFSET, l2_off);
      write_csr(CSR_L2_INDEX,  l2_idx);
      write_csr(CSR_L2_WAYS,   l2_ways);
      @(negedge clock);
      csr_we <= 1'b0;
      geometry_count++;
   endtask

   // Send one transaction after a random gap; predict it at the accepting edge
   task automatic send_access(input logic op, input logic [31:0] address);
      req_type item;
      int      gap;
      item.op      = op;
      item.address = address;
      gap = (gap_limit > 0) ? $urandom_range(gap_limit, 0) : 0;
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start       <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (busy !== 1'b0);
      pending_status_q.push_back(predict_status(item));
      accepted_count++;
   endtask

   // Drop start, drain outstanding results, then let the block go idle
   task automatic settle_pipeline();
      @(negedge clock);
      start <= 1'b0;
      while (pending_status_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Result checker: the receiver cannot stall, so grab every strobe
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type exp_status;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_status_q.size() == 0) begin
            report_mismatch($sformatf("result with nothing outstanding: l1=%0d l2=%0d",
                                      rsp_payload.l1_status, rsp_payload.l2_status));
         end else begin
            exp_status = pending_status_q.pop_front();
            checked_count++;
            if (exp_status.l1_status inside {STAT_RD_HIT, STAT_WR_HIT})
               l1_hit_count++;
            if (exp_status.l2_status inside {STAT_RD_HIT, STAT_WR_HIT})
               l2_hit_count++;
            if (rsp_payload.l1_status !== exp_status.l1_status)
               report_mismatch($sformatf("result %0d l1_status got %0d want %0d",
                                         checked_count, rsp_payload.l1_status,
                                         exp_status.l1_status));
            if (rsp_payload.l2_status !== exp_status.l2_status)
               report_mismatch($sformatf("result %0d l2_status got %0d want %0d",
                                         checked_count, rsp_payload.l2_status,
                                         exp_status.l2_status));
         end
      end
   end

   // Watchdog: trip when no transaction, result or CSR write moves for too long
   initial idle_cycles = 0;
   always @(posedge clock) begin
      if ((start === 1'b1 && busy === 1'b0) || rsp_valid === 1'b1 || csr_we === 1'b1)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Reset geometry: 32 B L1 lines, 64 sets, 4 ways; 64 B L2 lines, 256 sets, 8 ways
   task automatic test_reset_geometry();
      logic [31:0] base;
      base = 32'h1234_5680;
      gap_limit = 5;
      send_access(OP_READ,  base);            // cold miss in both levels
      send_access(OP_READ,  base);            // L1 read hit
      send_access(OP_WRITE, base);            // L1 write hit, L2 untouched
      send_access(OP_WRITE, base + 32'd32);   // other half of the L2 line: L2 write hit
      send_access(OP_READ,  base + 32'd32);   // L1 miss, L2 read hit
      send_access(OP_WRITE, 32'hDEAD_BEC0);   // write miss in both, no allocate
      send_access(OP_READ,  32'h0000_0000);
      send_access(OP_WRITE, 32'hFFFF_FFFF);
      send_access(OP_READ,  32'hFFFF_FFFF);
      // Thrash one L1 set past its four ways so the round-robin evicts the base line
      for (int k = 1; k <= 4; k++)
         send_access(OP_READ, base + k * 32'd2048);
      send_access(OP_READ, base);             // L1 lost it, L2 still holds it
      settle_pipeline();
   endtask

   // Smallest legal geometry, then every register at its largest encoding
   task automatic test_geometry_extremes();
      gap_limit = 0;
      set_geometry(5'd0, 5'd0, 5'd1, 5'd0, 5'd0, 5'd1);
      send_access(OP_READ,  32'h0000_0000);
      send_access(OP_READ,  32'h0000_0001);   // single line each level: evict
      send_access(OP_READ,  32'h0000_0000);
      send_access(OP_WRITE, 32'h0000_0001);
      settle_pipeline();
      // Oversized offsets, index clamped to the level maximum, ways clamped down
      set_geometry(5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31);
      send_access(OP_READ,  32'hFFFF_FFFF);
      send_access(OP_READ,  32'hFFFF_0000);
      send_access(OP_WRITE, 32'h0000_0000);
      send_access(OP_READ,  32'hFFFF_FFFF);
      settle_pipeline();
   endtask

   // Advance the round-robin pointers, then shrink the ways below them
   task automatic test_victim_pointer_shrink();
      gap_limit = 3;
      set_geometry(5'd0, 5'd0, 5'd4, 5'd0, 5'd0, 5'd4);
      for (int k = 1; k <= 6; k++)
         send_access(OP_READ, k * 32'h10);    // four fills, two evictions: pointer at 2
      settle_pipeline();
      // Zero ways acts as one; both pointers now sit beyond the ways in use
      set_geometry(5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd2);
      send_access(OP_READ, 32'h70);
      send_access(OP_READ, 32'h10);
      settle_pipeline();
   endtask

   // Reload the working set: half clustered around one base, half scattered
   task automatic seed_hot_lines();
      logic [31:0] base;
      base = $urandom;
      for (int i = 0; i < HOT_LINES; i++)
         hot_lines[i] = (i < HOT_LINES / 2) ? base ^ $urandom_range(32'hFFFF, 0) : $urandom;
   endtask

   // Mostly reuse the working set so hits and evictions happen; mix in strays
   function automatic logic [31:0] pick_address();
      int roll;
      roll = $urandom_range(99, 0);
      if (roll < 60)
         return hot_lines[$urandom_range(HOT_LINES - 1, 0)];
      if (roll < 85)
         return hot_lines[$urandom_range(HOT_LINES - 1, 0)] ^ (32'd1 << $urandom_range(20, 0));
      return $urandom;
   endfunction

   // Random traffic over several geometries: ordinary, tiny, and raw register values
   task automatic test_random_traffic();
      logic [4:0] cfg[6];
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p % 3)
            0: begin
               cfg[0] = $urandom_range(12, 0);  cfg[1] = $urandom_range(8, 0);
               cfg[2] = $urandom_range(8, 1);   cfg[3] = $urandom_range(12, 0);
               cfg[4] = $urandom_range(10, 0);  cfg[5] = $urandom_range(16, 1);
            end
            1: begin
               cfg[0] = $urandom_range(6, 0);   cfg[1] = $urandom_range(2, 0);
               cfg[2] = $urandom_range(3, 1);   cfg[3] = $urandom_range(6, 0);
               cfg[4] = $urandom_range(2, 0);   cfg[5] = $urandom_range(3, 1);
            end
            default: begin
               foreach (cfg[i]) cfg[i] = $urandom_range(31, 0);
            end
         endcase
         set_geometry(cfg[0], cfg[1], cfg[2], cfg[3], cfg[4], cfg[5]);
         seed_hot_lines();
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // Switch between back-to-back bursts and gappy traffic every 40 transactions
            if (n % 40 == 0)
               gap_limit = ($urandom_range(2, 0) == 0) ? 0 : 5;
            send_access(($urandom_range(99, 0) < 35) ? OP_WRITE : OP_READ, pick_address());
         end
         settle_pipeline();
      end
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      error_count    = 0;
      accepted_count = 0;
      checked_count  = 0;
      l1_hit_count   = 0;
      l2_hit_count   = 0;
      geometry_count = 1;
      gap_limit      = 0;
      geo_l1_offset  = 4'd5;
      geo_l1_index   = 4'd6;
      geo_l1_ways    = 4'd4;
      geo_l2_offset  = 4'd6;
      geo_l2_index   = 4'd8;
      geo_l2_ways    = 5'd8;
      foreach (valid_dir[l, s, w]) valid_dir[l][s][w] = 1'b0;
      foreach (rr_pointer[l, s]) rr_pointer[l][s] = 0;

      // Hold reset, then wait out the directory clearing sweep
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);

      test_reset_geometry();
      test_geometry_extremes();
      test_victim_pointer_shrink();
      test_random_traffic();
      settle_pipeline();

      $display("Covered %0d transactions over %0d cache geometries, %0d results checked.",
               accepted_count, geometry_count, checked_count);
      $display("Saw %0d L1 hits and %0d L2 hits; %0d mismatches.",
               l1_hit_count, l2_hit_count, error_count);
      if (error_count == 0 && pending_status_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
